// ===== sv/vwd_pkg.sv =====
// Shared types and constants for the vertex weld table: sizes, payload structs,
// controller states and the command/status bundles between controller and datapath.
// No dependencies.
package vwd_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int IDX_W        = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int OUT_IDX_W    = 10;
	localparam int THR_W        = 64;
	localparam logic [THR_W-1:0] THRESH_RESET = 64'd429497;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	typedef struct packed {
		logic               command;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
	} in_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] vertex_index;
		logic                 was_inserted;
		logic                 table_full;
	} out_t;

	// One stored table entry
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESP
	} ctrl_state_t;

	typedef enum logic [1:0] {
		RES_CLEAR,
		RES_MATCH,
		RES_INSERT,
		RES_FULL
	} res_kind_t;

	typedef struct packed {
		logic      load;
		logic      issue;
		logic      set_res;
		res_kind_t res_kind;
		logic      load_out;
	} vwd_cmd_t;

	typedef struct packed {
		logic issue_done;
		logic pipe_empty;
		logic hit;
		logic full;
	} vwd_status_t;

endpackage

// ===== sv/vwd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module vwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/vwd_ctrl.sv =====
// Controller state machine for the vertex weld table: sequences accept, table
// scan, result capture and output hand-off. Depends on vwd_pkg.
module vwd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_command,
	output logic                out_valid,
	input  logic                out_ready,
	input  vwd_pkg::vwd_status_t status,
	output vwd_pkg::vwd_cmd_t    cmd
);
	import vwd_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (in_command == CMD_CLEAR) ? ST_RESP : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.hit || (status.issue_done && status.pipe_empty)) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.res_kind = RES_CLEAR;
		in_ready     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_command == CMD_CLEAR) begin
						cmd.set_res  = 1'b1;
						cmd.res_kind = RES_CLEAR;
					end
				end
			end
			ST_SCAN: begin
				// lowest matching index reaches the pipe end first
				priority if (status.hit) begin
					cmd.set_res  = 1'b1;
					cmd.res_kind = RES_MATCH;
				end else if (status.issue_done && status.pipe_empty) begin
					cmd.set_res  = 1'b1;
					cmd.res_kind = status.full ? RES_FULL : RES_INSERT;
				end else begin
					cmd.issue = !status.issue_done;
				end
			end
			ST_RESP: begin
				cmd.load_out = !out_valid_q || out_ready;
			end
			default: begin
				cmd.load = 1'b0;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/vwd_datapath.sv =====
// Datapath for the vertex weld table: item register, entry count, table RAM,
// five-stage compare pipeline and result/output registers. Depends on vwd_pkg, vwd_ram.
module vwd_datapath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  vwd_pkg::in_t             in_data,
	input  logic                     cfg_valid,
	input  logic [vwd_pkg::THR_W-1:0] cfg_data,
	input  vwd_pkg::vwd_cmd_t        cmd,
	output vwd_pkg::vwd_status_t     status,
	output vwd_pkg::out_t            out_data
);
	import vwd_pkg::*;

	function automatic logic [31:0] abs_diff(logic signed [31:0] a, logic signed [31:0] b);
		logic signed [32:0] d;
		logic signed [32:0] m;
		d = {a[31], a} - {b[31], b};
		m = d[32] ? -d : d;
		return m[31:0];
	endfunction

	function automatic logic [OUT_IDX_W-1:0] to_out_idx(logic [IDX_W-1:0] idx);
		logic [IDX_W+OUT_IDX_W-1:0] w;
		w = {{OUT_IDX_W{1'b0}}, idx};
		return w[OUT_IDX_W-1:0];
	endfunction

	in_t              item_q;
	logic [THR_W-1:0] thr_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] issue_q;
	out_t             res_q;
	out_t             out_q;

	entry_t           wr_entry;
	entry_t           rd_entry;
	logic             ram_wr;

	logic             vld_s1, vld_s2, vld_s3, vld_s4, hit_s5;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic             neq_s2, neq_s3, neq_s4;
	logic [31:0]      dx_s2, dy_s2, dz_s2;
	logic [63:0]      sqx_s3, sqy_s3, sqz_s3;
	logic [65:0]      sum_s4;

	assign ram_wr = cmd.set_res && (cmd.res_kind == RES_INSERT);

	assign wr_entry.pos_x  = item_q.pos_x;
	assign wr_entry.pos_y  = item_q.pos_y;
	assign wr_entry.pos_z  = item_q.pos_z;
	assign wr_entry.norm_x = item_q.norm_x;
	assign wr_entry.norm_y = item_q.norm_y;
	assign wr_entry.norm_z = item_q.norm_z;

	vwd_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_VERTICES)
	) u_table (
		.clk    (clk),
		.wr_en  (ram_wr),
		.wr_addr(count_q[IDX_W-1:0]),
		.wr_data(wr_entry),
		.rd_en  (cmd.issue),
		.rd_addr(issue_q[IDX_W-1:0]),
		.rd_data(rd_entry)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= THRESH_RESET;
			count_q <= '0;
			issue_q <= '0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			hit_s5  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				thr_q <= cfg_data;
			end
			if (cmd.load) begin
				issue_q <= '0;
			end else if (cmd.issue) begin
				issue_q <= issue_q + 1'b1;
			end
			if (cmd.set_res) begin
				if (cmd.res_kind == RES_CLEAR) begin
					count_q <= '0;
				end else if (cmd.res_kind == RES_INSERT) begin
					count_q <= count_q + 1'b1;
				end
			end
			// drop anything left in flight from the previous item
			if (cmd.load) begin
				vld_s1 <= 1'b0;
				vld_s2 <= 1'b0;
				vld_s3 <= 1'b0;
				vld_s4 <= 1'b0;
				hit_s5 <= 1'b0;
			end else begin
				vld_s1 <= cmd.issue;
				vld_s2 <= vld_s1;
				vld_s3 <= vld_s2;
				vld_s4 <= vld_s3;
				hit_s5 <= vld_s4 && neq_s4 && (sum_s4[65:64] == 2'b00)
					&& (sum_s4[63:0] < thr_q);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
		idx_s1 <= issue_q[IDX_W-1:0];

		idx_s2 <= idx_s1;
		dx_s2  <= abs_diff(item_q.pos_x, rd_entry.pos_x);
		dy_s2  <= abs_diff(item_q.pos_y, rd_entry.pos_y);
		dz_s2  <= abs_diff(item_q.pos_z, rd_entry.pos_z);
		neq_s2 <= (item_q.norm_x == rd_entry.norm_x) && (item_q.norm_y == rd_entry.norm_y)
			&& (item_q.norm_z == rd_entry.norm_z);

		idx_s3 <= idx_s2;
		neq_s3 <= neq_s2;
		sqx_s3 <= dx_s2 * dx_s2;
		sqy_s3 <= dy_s2 * dy_s2;
		sqz_s3 <= dz_s2 * dz_s2;

		idx_s4 <= idx_s3;
		neq_s4 <= neq_s3;
		sum_s4 <= {2'b00, sqx_s3} + {2'b00, sqy_s3} + {2'b00, sqz_s3};

		idx_s5 <= idx_s4;

		if (cmd.set_res) begin
			unique case (cmd.res_kind)
				RES_CLEAR:  res_q <= '0;
				RES_MATCH:  res_q <= '{to_out_idx(idx_s5), 1'b0, 1'b0};
				RES_INSERT: res_q <= '{to_out_idx(count_q[IDX_W-1:0]), 1'b1, 1'b0};
				RES_FULL:   res_q <= '{{OUT_IDX_W{1'b0}}, 1'b0, 1'b1};
				default:    res_q <= '0;
			endcase
		end
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

	assign status.issue_done = (issue_q == count_q);
	assign status.pipe_empty = !(vld_s1 || vld_s2 || vld_s3 || vld_s4 || hit_s5);
	assign status.hit        = hit_s5;
	assign status.full       = (count_q == CNT_W'(MAX_VERTICES));
	assign out_data          = out_q;

endmodule

// ===== sv/vertex_weld_dedup_table.sv =====
// Top level of the vertex weld table: joins controller and datapath.
// Depends on vwd_pkg, vwd_ctrl, vwd_datapath.
//
//   Channel   Signals                        Moves
//   in        in_valid/in_ready, in_data     clear command or vertex lookup
//   out       out_valid/out_ready, out_data  index, inserted flag, full flag
//   cfg       cfg_valid/cfg_ready, cfg_data  squared weld distance, Q32.32
//
// A vertex transaction reads entries, one per cycle through the table RAM read port into a
// five-stage compare pipeline, up to the first match and at most the entry count, and
// then raises out_valid; an empty table reads none. A clear raises out_valid without a
// table scan. One item is in work at a time; the next may be accepted while a result
// waits, and a new result holds until the output is free.
// Reset empties the table and restores the default threshold; cfg is always ready.
module vertex_weld_dedup_table (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  vwd_pkg::in_t             in_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output vwd_pkg::out_t            out_data,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [vwd_pkg::THR_W-1:0] cfg_data
);
	import vwd_pkg::*;

	vwd_cmd_t    cmd;
	vwd_status_t status;

	assign cfg_ready = 1'b1;

	vwd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_command(in_data.command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	vwd_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);

endmodule

// ===== bench/tb_vertex_weld_dedup_table.sv =====
`timescale 1ns / 100ps
// Self-checking bench for vertex_weld_dedup_table: directed rows, random weld traffic over
// several thresholds and idling mixes, then a pass that fills the table. Depends on vwd_pkg, vertex_weld_dedup_table.
module tb_vertex_weld_dedup_table;
	import vwd_pkg::*;

	localparam int CYCLE_LIMIT = 12_000_000;
	localparam int SEG_COUNT   = 6;
	localparam int SEG_ITEMS   = 97;
	localparam int TAIL_CYCLES = MAX_VERTICES + 64;
	localparam int SEND_IDLE [4] = '{0, 73, 0, 23};
	localparam int RECV_STALL [4] = '{0, 0, 73, 23};

	typedef struct {
		in_t  item;
		bit   typed;
		out_t want;
	} stim_row_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	in_t              in_data   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_t             out_data;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [THR_W-1:0] cfg_data  = '0;

	// Shadow copy of the weld table and threshold
	entry_t           weld_tbl [MAX_VERTICES];
	int               entry_cnt;
	logic [THR_W-1:0] weld_thr_sq;

	out_t             pending_welds [$];
	in_t              recent_verts [$];
	in_t              common_norms [4];
	stim_row_t        directed_rows [$];
	int               send_idle_pct;
	int               recv_stall_pct;
	int               error_count;
	int               cycle_count = 0;

	vertex_weld_dedup_table u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] abs_gap(logic [31:0] a, logic [31:0] b);
		logic signed [32:0] d;
		d = $signed({a[31], a}) - $signed({b[31], b});
		return d[32] ? 32'(-d) : d[31:0];
	endfunction

	// Squared distance in Q32.32, saturating at all ones
	function automatic logic [63:0] weld_dist_sq(entry_t e, in_t v);
		logic [31:0] gx, gy, gz;
		logic [63:0] qx, qy, qz;
		logic [65:0] s;
		gx = abs_gap(e.pos_x, v.pos_x);
		gy = abs_gap(e.pos_y, v.pos_y);
		gz = abs_gap(e.pos_z, v.pos_z);
		qx = {32'd0, gx} * {32'd0, gx};
		qy = {32'd0, gy} * {32'd0, gy};
		qz = {32'd0, gz} * {32'd0, gz};
		s = {2'b00, qx} + {2'b00, qy} + {2'b00, qz};
		return (s[65:64] != 2'b00) ? '1 : s[63:0];
	endfunction

	// Search the shadow table lowest index first; append on a miss
	function automatic out_t weld_lookup(in_t v);
		out_t r;
		entry_t e;
		r = '0;
		if (v.command == CMD_CLEAR) begin
			entry_cnt = 0;
			return r;
		end
		for (int i = 0; i < entry_cnt; i++) begin
			e = weld_tbl[i];
			if (e.norm_x == v.norm_x && e.norm_y == v.norm_y && e.norm_z == v.norm_z &&
					weld_dist_sq(e, v) < weld_thr_sq) begin
				r.vertex_index = OUT_IDX_W'(i);
				return r;
			end
		end
		if (entry_cnt >= MAX_VERTICES) begin
			r.table_full = 1'b1;
			return r;
		end
		weld_tbl[entry_cnt] = '{v.pos_x, v.pos_y, v.pos_z, v.norm_x, v.norm_y, v.norm_z};
		r.vertex_index = OUT_IDX_W'(entry_cnt);
		r.was_inserted = 1'b1;
		entry_cnt++;
		return r;
	endfunction

	function automatic in_t mk_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
		in_t v;
		v.command = CMD_LOOKUP;
		v.pos_x = x;
		v.pos_y = y;
		v.pos_z = z;
		v.norm_x = nx;
		v.norm_y = ny;
		v.norm_z = nz;
		return v;
	endfunction

	// Clear with random bits in the ignored fields
	function automatic in_t mk_clear();
		in_t v;
		v = mk_vertex($urandom, $urandom, $urandom,
			16'($urandom), 16'($urandom), 16'($urandom));
		v.command = CMD_CLEAR;
		return v;
	endfunction

	function automatic void add_row(in_t v, bit typed, out_t want);
		stim_row_t row;
		row.item = v;
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endfunction

	// Often near repeats of recent vertices, so lookups hit and miss around the threshold
	function automatic in_t rand_vertex(int span);
		in_t v;
		int pick;
		int k;
		pick = $urandom_range(0, 99);
		if (pick < 6)
			return mk_clear();
		if (pick < 50 && recent_verts.size() > 0) begin
			v = recent_verts[$urandom_range(0, recent_verts.size() - 1)];
			v.pos_x = 32'(v.pos_x) + 32'($urandom_range(0, 2 * span)) - 32'(span);
			v.pos_y = 32'(v.pos_y) + 32'($urandom_range(0, 2 * span)) - 32'(span);
			v.pos_z = 32'(v.pos_z) + 32'($urandom_range(0, 2 * span)) - 32'(span);
		end else if (pick < 62 && recent_verts.size() > 0) begin
			v = recent_verts[$urandom_range(0, recent_verts.size() - 1)];
			v.pos_x = $urandom;
			v.pos_y = $urandom;
			v.pos_z = $urandom;
		end else begin
			v = mk_vertex($urandom, $urandom, $urandom,
				16'($urandom), 16'($urandom), 16'($urandom));
			if (pick < 80) begin
				k = $urandom_range(0, 3);
				v.norm_x = common_norms[k].norm_x;
				v.norm_y = common_norms[k].norm_y;
				v.norm_z = common_norms[k].norm_z;
			end
		end
		v.command = CMD_LOOKUP;
		recent_verts.push_back(v);
		if (recent_verts.size() > 32)
			void'(recent_verts.pop_front());
		return v;
	endfunction

	task automatic send_item(in_t v, bit typed, out_t want);
		out_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= v;
		do @(posedge clk); while (in_ready !== 1'b1);
		predicted = weld_lookup(v);
		pending_welds.push_back(typed ? want : predicted);
	endtask

	// Hold off until every transaction has drained; waits on the clock even when nothing is pending
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_welds.size() != 0);
	endtask

	task automatic write_threshold(logic [THR_W-1:0] thr);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= thr;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		weld_thr_sq = thr;
	endtask

	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (pending_welds.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected result: index %0d inserted %0b full %0b",
						out_data.vertex_index, out_data.was_inserted, out_data.table_full);
			end else begin
				want = pending_welds.pop_front();
				if (out_data.vertex_index !== want.vertex_index ||
						out_data.was_inserted !== want.was_inserted ||
						out_data.table_full !== want.table_full) begin
					error_count++;
					if (error_count <= 10)
						$display({"mismatch at %0t: expected index %0d ins %0b full %0b,",
							" got index %0d ins %0b full %0b"},
							$realtime, want.vertex_index, want.was_inserted, want.table_full,
							out_data.vertex_index, out_data.was_inserted, out_data.table_full);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", pending_welds.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : stimulus
		logic [THR_W-1:0] seg_thr [SEG_COUNT];
		int               seg_span [SEG_COUNT];
		in_t              fill_verts [MAX_VERTICES];
		in_t              v;

		entry_cnt = 0;
		weld_thr_sq = THRESH_RESET;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		error_count = 0;
		foreach (common_norms[k])
			common_norms[k] = mk_vertex(0, 0, 0, 16'($urandom), 16'($urandom), 16'($urandom));

		add_row(mk_vertex(0, 0, 0, 0, 0, 0), 1'b1, '{10'd0, 1'b1, 1'b0});
		add_row(mk_vertex(0, 0, 0, 0, 0, 0), 1'b1, '{10'd0, 1'b0, 1'b0});
		add_row(mk_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h7fff, 16'h7fff, 16'h7fff),
			1'b1, '{10'd1, 1'b1, 1'b0});
		add_row(mk_vertex(32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000, 16'h8000),
			1'b1, '{10'd2, 1'b1, 1'b0});
		// distance to the max-corner entry saturates, so no weld
		add_row(mk_vertex(32'h80000000, 32'h80000000, 32'h80000000, 16'h7fff, 16'h7fff, 16'h7fff),
			1'b1, '{10'd3, 1'b1, 1'b0});
		add_row(mk_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h7fff, 16'h7fff, 16'h7fff),
			1'b1, '{10'd1, 1'b0, 1'b0});
		// squared distance exactly at the default threshold, then one step inside it
		add_row(mk_vertex(654, 41, 10, 0, 0, 0), 1'b0, '0);
		add_row(mk_vertex(654, 41, 9, 0, 0, 0), 1'b0, '0);
		add_row(mk_vertex(0, 0, 0, 16'h0001, 0, 0), 1'b0, '0);
		add_row(mk_vertex('1, '1, '1, 16'hffff, 16'hffff, 16'hffff), 1'b0, '0);
		add_row(mk_vertex(32'h00010000, 0, 0, 0, 0, 0), 1'b0, '0);
		add_row(mk_clear(), 1'b1, '0);
		add_row(mk_clear(), 1'b1, '0);
		add_row(mk_vertex(0, 0, 0, 16'h2000, 16'h2000, 16'h2000), 1'b1, '{10'd0, 1'b1, 1'b0});
		add_row(mk_vertex(32'h7fffffff, 32'h80000000, 0, 16'h2000, 16'h2000, 16'h2000),
			1'b0, '0);

		seg_thr = '{THRESH_RESET, '0, '1, 64'h0000_0100_0000_0000,
			{$urandom, $urandom}, THRESH_RESET};
		seg_span = '{1024, 1024, 1 << 24, 1 << 21, 1 << 20, 1024};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[n])
			send_item(directed_rows[n].item, directed_rows[n].typed, directed_rows[n].want);

		for (int s = 0; s < SEG_COUNT; s++) begin
			write_threshold(seg_thr[s]);
			send_idle_pct = SEND_IDLE[s % 4];
			recv_stall_pct = RECV_STALL[s % 4];
			for (int n = 0; n < SEG_ITEMS; n++) begin
				if (n == SEG_ITEMS / 2 || $urandom_range(0, 59) == 0)
					wait_drained();
				send_item(rand_vertex(seg_span[s]), 1'b0, '0);
			end
		end

		// Fill every slot with a distinct normal, then probe the full table
		send_idle_pct = 23;
		recv_stall_pct = 23;
		send_item(mk_clear(), 1'b1, '0);
		for (int n = 0; n < MAX_VERTICES; n++) begin
			fill_verts[n] = mk_vertex($urandom, $urandom, $urandom,
				16'(n), 16'($urandom), 16'($urandom));
			send_item(fill_verts[n], 1'b1, '{OUT_IDX_W'(n), 1'b1, 1'b0});
		end
		v = mk_vertex($urandom, $urandom, $urandom,
			16'($urandom_range(MAX_VERTICES, 65535)), 16'($urandom), 16'($urandom));
		send_item(v, 1'b1, '{10'd0, 1'b0, 1'b1});
		send_item(fill_verts[MAX_VERTICES - 1], 1'b1, '{10'd1023, 1'b0, 1'b0});
		send_item(fill_verts[0], 1'b1, '{10'd0, 1'b0, 1'b0});
		v = fill_verts[517];
		v.pos_x = 32'(v.pos_x) + 32'd1;
		send_item(v, 1'b0, '0);
		v = mk_vertex($urandom, $urandom, $urandom,
			16'($urandom_range(MAX_VERTICES, 65535)), 16'($urandom), 16'($urandom));
		send_item(v, 1'b1, '{10'd0, 1'b0, 1'b1});
		send_item(mk_clear(), 1'b1, '0);
		send_item(fill_verts[MAX_VERTICES - 1], 1'b1, '{10'd0, 1'b1, 1'b0});

		recv_stall_pct = 0;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_welds.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/vwd_pkg.sv
sv/vwd_ram.sv
sv/vwd_ctrl.sv
sv/vwd_datapath.sv
sv/vertex_weld_dedup_table.sv
bench/tb_vertex_weld_dedup_table.sv
